// ===== hw/rtl/clx_pkg.sv =====
package clx_pkg;

  // Coordinate and register widths.
  localparam int CW = 20;
  localparam int RW = CW - 1;
  localparam int CFG_IDX_W = 2;

  // Datapath widths, all derived from the coordinate width.
  localparam int TW    = CW + 1;        // point moved into the circle frame
  localparam int DW    = CW + 2;        // line direction
  localparam int DR2W  = 2 * DW;        // squared direction length
  localparam int PW    = 2 * TW;        // cross products of the determinant
  localparam int DETW  = PW + 1;        // determinant
  localparam int ADW   = PW;            // determinant magnitude
  localparam int R2W   = 2 * RW;        // squared radius
  localparam int DISCW = 2 * ADW;       // discriminant
  localparam int SQW   = DISCW / 2;     // square root of the discriminant
  localparam int NW    = ADW + DW + 2;  // signed numerator
  localparam int NMW   = NW - 1;        // numerator magnitude
  localparam int QW    = CW;            // quotient magnitude
  localparam int LANES = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(2);

  localparam logic [1:0] HITS_NONE = 2'd0;
  localparam logic [1:0] HITS_ONE  = 2'd1;
  localparam logic [1:0] HITS_TWO  = 2'd2;

  localparam int LANE_X0 = 0;
  localparam int LANE_Y0 = 1;
  localparam int LANE_X1 = 2;
  localparam int LANE_Y1 = 3;

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
  } in_t;

  typedef struct packed {
    logic [1:0]           hit_count;
    logic signed [CW-1:0] hit0_x;
    logic signed [CW-1:0] hit0_y;
    logic signed [CW-1:0] hit1_x;
    logic signed [CW-1:0] hit1_y;
    logic                 degenerate;
  } out_t;

  // Data that rides along with the square root.
  typedef struct packed {
    logic signed [NW-1:0] bx;
    logic signed [NW-1:0] by;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic                 ex_neg;
    logic [DR2W-1:0]      dr2;
    logic                 degen;
    logic                 nohit;
    logic                 tangent;
  } sq_side_t;

  // Data that rides along with the divider.
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             degen;
    logic             nohit;
    logic             tangent;
  } dv_side_t;

endpackage

// ===== hw/rtl/clx_sqrt.sv =====
module clx_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [clx_pkg::DISCW-1:0]  in_rad,
  input  clx_pkg::sq_side_t          in_side,
  output logic                       out_valid,
  output logic [clx_pkg::SQW-1:0]    out_root,
  output clx_pkg::sq_side_t          out_side
);

  localparam int N  = clx_pkg::SQW;
  localparam int RW = clx_pkg::DISCW;

  logic              vld_r  [N];
  logic [RW-1:0]     rem_r  [N];
  logic [N-1:0]      root_r [N];
  clx_pkg::sq_side_t side_r [N];

  // One result bit per stage, most significant first.
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int B = N - 1 - i;
    logic              vld_in;
    logic [RW-1:0]     rem_in;
    logic [N-1:0]      root_in;
    clx_pkg::sq_side_t side_in;
    logic [RW:0]       trial;
    logic [RW-1:0]     rem_nxt;
    logic [N-1:0]      root_nxt;

    if (i == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      trial = ((RW + 1)'(root_in) << (B + 1)) | ((RW + 1)'(1) << (2 * B));
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt  = rem_in - trial[RW-1:0];
        root_nxt = root_in | (N'(1) << B);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hw/rtl/clx_div.sv =====
module clx_div (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic [clx_pkg::LANES-1:0][clx_pkg::NMW-1:0] in_num,
  input  logic [clx_pkg::DR2W-1:0]                    in_den,
  input  clx_pkg::dv_side_t                           in_side,
  output logic                                        out_valid,
  output logic [clx_pkg::LANES-1:0][clx_pkg::QW-1:0]  out_quo,
  output clx_pkg::dv_side_t                           out_side
);

  localparam int N  = clx_pkg::QW;
  localparam int L  = clx_pkg::LANES;
  localparam int MW = clx_pkg::NMW;

  logic                     vld_r  [N];
  logic [L-1:0][MW-1:0]     rem_r  [N];
  logic [L-1:0][N-1:0]      quo_r  [N];
  logic [clx_pkg::DR2W-1:0] den_r  [N];
  clx_pkg::dv_side_t        side_r [N];

  // Restoring division, one quotient bit per stage, four lanes sharing the divisor.
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int K = N - 1 - i;
    logic                     vld_in;
    logic [L-1:0][MW-1:0]     rem_in;
    logic [L-1:0][N-1:0]      quo_in;
    logic [clx_pkg::DR2W-1:0] den_in;
    clx_pkg::dv_side_t        side_in;
    logic [MW-1:0]            shifted;
    logic [L-1:0][MW-1:0]     rem_nxt;
    logic [L-1:0][N-1:0]      quo_nxt;

    if (i == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      shifted = MW'(den_in) << K;
      for (int l = 0; l < L; l++) begin
        if (rem_in[l] >= shifted) begin
          rem_nxt[l] = rem_in[l] - shifted;
          quo_nxt[l] = quo_in[l] | (N'(1) << K);
        end else begin
          rem_nxt[l] = rem_in[l];
          quo_nxt[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i]  <= rem_nxt;
      quo_r[i]  <= quo_nxt;
      den_r[i]  <= den_in;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hw/rtl/circle_line_intersection.sv =====
// Circle-line intersection.
// The circle (center x, center y, radius) sits in three configuration registers
// written through the cfg_ channel: cfg_index selects the register and the write
// happens at an edge where cfg_valid and cfg_ready are high. cfg_ready is always
// high, and an index past the radius register is ignored.
// An item is a line through two points on in_data. It is taken at every edge
// where start is high and busy is low; busy is always low, so one item can enter
// in every cycle and the block sustains one item per cycle.
// Each item gives exactly one result on out_data, marked by out_strobe for one
// cycle. Each item passes the 42-stage square root of the discriminant and the
// 20-stage divider, plus twelve stages of translation, products, partial-product
// multiplies and saturation.
// The receiver cannot stall, so results simply leave in order.
// Reset clears the registers to zero (center at the origin, radius zero) and
// drops every item in flight; no result appears for those items.
// Configuration must only change while no item is in flight.
module circle_line_intersection (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  clx_pkg::in_t                   in_data,
  output logic                           out_strobe,
  output clx_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clx_pkg::CW-1:0]         cfg_data
);

  localparam int CW    = clx_pkg::CW;
  localparam int RW    = clx_pkg::RW;
  localparam int TW    = clx_pkg::TW;
  localparam int DW    = clx_pkg::DW;
  localparam int DR2W  = clx_pkg::DR2W;
  localparam int PW    = clx_pkg::PW;
  localparam int DETW  = clx_pkg::DETW;
  localparam int ADW   = clx_pkg::ADW;
  localparam int R2W   = clx_pkg::R2W;
  localparam int DISCW = clx_pkg::DISCW;
  localparam int SQW   = clx_pkg::SQW;
  localparam int NW    = clx_pkg::NW;
  localparam int NMW   = clx_pkg::NMW;
  localparam int QW    = clx_pkg::QW;
  localparam int LANES = clx_pkg::LANES;

  // Wide products are split into four 24 by 24 bit partial products.
  localparam int HW  = 24;
  localparam int OPW = 2 * HW;
  localparam int PPW = 2 * OPW;

  localparam int LATENCY = 12 + SQW + QW;

  localparam logic signed [CW+1:0] SAT_HI = (CW + 2)'((1 << (CW - 1)) - 1);
  localparam logic signed [CW+1:0] SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [OPW-1:0] ll;
    logic [OPW-1:0] lh;
    logic [OPW-1:0] hl;
    logic [OPW-1:0] hh;
  } pp_t;

  typedef struct packed {
    logic [DW-1:0]   adx;
    logic [DW-1:0]   ady;
    logic            ex_neg;
    logic            bx_neg;
    logic            by_neg;
    logic [DR2W-1:0] dr2;
    logic            degen;
  } mside_t;

  function automatic pp_t pp_mul(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
    pp_t p;
    p.ll = a[HW-1:0]    * b[HW-1:0];
    p.lh = a[HW-1:0]    * b[OPW-1:HW];
    p.hl = a[OPW-1:HW]  * b[HW-1:0];
    p.hh = a[OPW-1:HW]  * b[OPW-1:HW];
    return p;
  endfunction

  function automatic logic [PPW-1:0] pp_sum(input pp_t p);
    logic [PPW-1:0] s;
    s = PPW'(p.ll) + (PPW'(p.lh) << HW) + (PPW'(p.hl) << HW) + (PPW'(p.hh) << OPW);
    return s;
  endfunction

  function automatic logic [NMW-1:0] mag(input logic signed [NW-1:0] v);
    logic signed [NW-1:0] a;
    a = v[NW-1] ? -v : v;
    return a[NMW-1:0];
  endfunction

  // Applies the sign, adds the center back and clamps to the coordinate range.
  function automatic logic [CW-1:0] place(input logic [QW-1:0] q, input logic neg,
                                          input logic signed [CW-1:0] c);
    logic signed [CW+1:0] qs;
    logic signed [CW+1:0] sum;
    logic [CW-1:0]        res;
    qs  = $signed({2'b00, q});
    if (neg) begin
      qs = -qs;
    end
    sum = qs + (CW + 2)'(c);
    if (sum > SAT_HI) begin
      res = SAT_HI[CW-1:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[CW-1:0];
    end else begin
      res = sum[CW-1:0];
    end
    return res;
  endfunction

  // Handshakes: nothing ever holds the block off.
  logic accept;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers. The squared radius is kept ready for the multiplier.
  logic signed [CW-1:0] cx_r;
  logic signed [CW-1:0] cy_r;
  logic [RW-1:0]        rad_r;
  logic [R2W-1:0]       r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clx_pkg::REG_CENTER_X: cx_r  <= cfg_data;
        clx_pkg::REG_CENTER_Y: cy_r  <= cfg_data;
        clx_pkg::REG_RADIUS:   rad_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
    r2_r <= R2W'(rad_r) * R2W'(rad_r);
  end

  // Stage 1: move both points into the circle's frame.
  logic                 v1_r;
  logic signed [TW-1:0] x1_r, y1_r, x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    x1_r <= TW'(in_data.first_x) - TW'(cx_r);
    y1_r <= TW'(in_data.first_y) - TW'(cy_r);
    x2_r <= TW'(in_data.second_x) - TW'(cx_r);
    y2_r <= TW'(in_data.second_y) - TW'(cy_r);
  end

  // Stage 2: direction and the two cross products.
  logic                 v2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic signed [PW-1:0] p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dx2_r <= DW'(x2_r) - DW'(x1_r);
    dy2_r <= DW'(y2_r) - DW'(y1_r);
    p1_r  <= PW'(x1_r) * PW'(y2_r);
    p2_r  <= PW'(x2_r) * PW'(y1_r);
  end

  // Stage 3: squared direction length and determinant.
  logic                   v3_r;
  logic [DR2W-1:0]        dr23_r;
  logic signed [DETW-1:0] det3_r;
  logic signed [DW-1:0]   dx3_r, dy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    dr23_r <= DR2W'(dx2_r) * DR2W'(dx2_r) + DR2W'(dy2_r) * DR2W'(dy2_r);
    det3_r <= DETW'(p1_r) - DETW'(p2_r);
    dx3_r  <= dx2_r;
    dy3_r  <= dy2_r;
  end

  // Stage 4: magnitudes and signs for the unsigned multipliers.
  logic signed [DETW-1:0] det_abs;
  logic signed [DW-1:0]   dx_abs, dy_abs;
  logic                   v4_r;
  logic [ADW-1:0]         adet4_r;
  logic                   det_neg4_r, dx_neg4_r, dy_neg4_r;
  logic [DW-1:0]          adx4_r, ady4_r;
  logic [DR2W-1:0]        dr24_r;
  logic                   degen4_r;

  assign det_abs = det3_r[DETW-1] ? -det3_r : det3_r;
  assign dx_abs  = dx3_r[DW-1] ? -dx3_r : dx3_r;
  assign dy_abs  = dy3_r[DW-1] ? -dy3_r : dy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    adet4_r    <= det_abs[ADW-1:0];
    det_neg4_r <= det3_r[DETW-1];
    dx_neg4_r  <= dx3_r[DW-1];
    dy_neg4_r  <= dy3_r[DW-1];
    adx4_r     <= dx_abs;
    ady4_r     <= dy_abs;
    dr24_r     <= dr23_r;
    degen4_r   <= (dr23_r == '0);
  end

  // Stages 5 and 6: r*r*dr2, det*det and the two det products, as partial
  // products and then their sums.
  logic   vm1_r, vm2_r;
  pp_t    pp_p_r, pp_q_r, pp_bx_r, pp_by_r;
  mside_t m1_side_r, m2_side_r;
  logic [PPW-1:0] p_full, q_full, bx_full, by_full;
  logic [DISCW-1:0] p_r, q_r;
  logic [NMW-1:0]   bxm_r, bym_r;

  assign p_full  = pp_sum(pp_p_r);
  assign q_full  = pp_sum(pp_q_r);
  assign bx_full = pp_sum(pp_bx_r);
  assign by_full = pp_sum(pp_by_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
    end else begin
      vm1_r <= v4_r;
      vm2_r <= vm1_r;
    end
    pp_p_r  <= pp_mul(OPW'(r2_r), OPW'(dr24_r));
    pp_q_r  <= pp_mul(OPW'(adet4_r), OPW'(adet4_r));
    pp_bx_r <= pp_mul(OPW'(adet4_r), OPW'(ady4_r));
    pp_by_r <= pp_mul(OPW'(adet4_r), OPW'(adx4_r));
    m1_side_r.adx    <= adx4_r;
    m1_side_r.ady    <= ady4_r;
    // The sign of the x root term flips with the sign of dx and with the sign of dy.
    m1_side_r.ex_neg <= dx_neg4_r ^ dy_neg4_r;
    m1_side_r.bx_neg <= det_neg4_r ^ dy_neg4_r;
    m1_side_r.by_neg <= ~(det_neg4_r ^ dx_neg4_r);
    m1_side_r.dr2    <= dr24_r;
    m1_side_r.degen  <= degen4_r;
    p_r       <= p_full[DISCW-1:0];
    q_r       <= q_full[DISCW-1:0];
    bxm_r     <= bx_full[NMW-1:0];
    bym_r     <= by_full[NMW-1:0];
    m2_side_r <= m1_side_r;
  end

  // Stage 7: discriminant and its sign, signed det terms.
  logic [DISCW:0]       dsub;
  logic signed [NW-1:0] bxs, bys;
  logic                 v5_r;
  logic [DISCW-1:0]     disc5_r;
  clx_pkg::sq_side_t    side5_r;

  assign dsub = {1'b0, p_r} - {1'b0, q_r};
  assign bxs  = $signed({1'b0, bxm_r});
  assign bys  = $signed({1'b0, bym_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= vm2_r;
    end
    disc5_r         <= dsub[DISCW-1:0];
    side5_r.bx      <= m2_side_r.bx_neg ? -bxs : bxs;
    side5_r.by      <= m2_side_r.by_neg ? -bys : bys;
    side5_r.adx     <= m2_side_r.adx;
    side5_r.ady     <= m2_side_r.ady;
    side5_r.ex_neg  <= m2_side_r.ex_neg;
    side5_r.dr2     <= m2_side_r.dr2;
    side5_r.degen   <= m2_side_r.degen;
    side5_r.nohit   <= dsub[DISCW];
    side5_r.tangent <= (dsub[DISCW-1:0] == '0);
  end

  // Floor square root of the discriminant.
  logic              sq_valid;
  logic [SQW-1:0]    sq_root;
  clx_pkg::sq_side_t sq_side;

  clx_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_rad    (disc5_r),
    .in_side   (side5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Two more stages: |dx|*s and |dy|*s.
  logic              vm3_r, vm4_r;
  pp_t               pp_ex_r, pp_ey_r;
  clx_pkg::sq_side_t m3_side_r, m4_side_r;
  logic [PPW-1:0]    ex_full, ey_full;
  logic [NMW-1:0]    exm_r, eym_r;

  assign ex_full = pp_sum(pp_ex_r);
  assign ey_full = pp_sum(pp_ey_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm3_r <= 1'b0;
      vm4_r <= 1'b0;
    end else begin
      vm3_r <= sq_valid;
      vm4_r <= vm3_r;
    end
    pp_ex_r   <= pp_mul(OPW'(sq_side.adx), OPW'(sq_root));
    pp_ey_r   <= pp_mul(OPW'(sq_side.ady), OPW'(sq_root));
    m3_side_r <= sq_side;
    exm_r     <= ex_full[NMW-1:0];
    eym_r     <= ey_full[NMW-1:0];
    m4_side_r <= m3_side_r;
  end

  // Numerators of the four coordinates.
  logic signed [NW-1:0] exs, eys, ex;
  logic                 v6_r;
  logic signed [NW-1:0] n0x_r, n0y_r, n1x_r, n1y_r;
  clx_pkg::sq_side_t    side6_r;

  assign exs = $signed({1'b0, exm_r});
  assign eys = $signed({1'b0, eym_r});
  assign ex  = m4_side_r.ex_neg ? -exs : exs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= vm4_r;
    end
    n0x_r   <= m4_side_r.bx + ex;
    n1x_r   <= m4_side_r.bx - ex;
    n0y_r   <= m4_side_r.by + eys;
    n1y_r   <= m4_side_r.by - eys;
    side6_r <= m4_side_r;
  end

  // Split the numerators into magnitude and sign for the divider, which
  // therefore truncates toward zero.
  logic                            v7_r;
  logic [LANES-1:0][NMW-1:0]       num7_r;
  logic [DR2W-1:0]                 den7_r;
  clx_pkg::dv_side_t               side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    num7_r[clx_pkg::LANE_X0]      <= mag(n0x_r);
    num7_r[clx_pkg::LANE_Y0]      <= mag(n0y_r);
    num7_r[clx_pkg::LANE_X1]      <= mag(n1x_r);
    num7_r[clx_pkg::LANE_Y1]      <= mag(n1y_r);
    side7_r.neg[clx_pkg::LANE_X0] <= n0x_r[NW-1];
    side7_r.neg[clx_pkg::LANE_Y0] <= n0y_r[NW-1];
    side7_r.neg[clx_pkg::LANE_X1] <= n1x_r[NW-1];
    side7_r.neg[clx_pkg::LANE_Y1] <= n1y_r[NW-1];
    side7_r.degen                 <= side6_r.degen;
    side7_r.nohit                 <= side6_r.nohit;
    side7_r.tangent               <= side6_r.tangent;
    den7_r                        <= side6_r.dr2;
  end

  logic                      dv_valid;
  logic [LANES-1:0][QW-1:0]  dv_quo;
  clx_pkg::dv_side_t         dv_side;

  clx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .in_num    (num7_r),
    .in_den    (den7_r),
    .in_side   (side7_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Final stage: pick the case and form the result item. A line with equal
  // points, or one that misses the circle, returns all coordinates zero; a
  // tangent line returns only the first point.
  clx_pkg::out_t res_nxt;
  logic          out_strobe_r;
  clx_pkg::out_t out_data_r;

  always_comb begin
    res_nxt = '0;
    if (dv_side.degen) begin
      res_nxt.degenerate = 1'b1;
    end else if (!dv_side.nohit) begin
      res_nxt.hit0_x = place(dv_quo[clx_pkg::LANE_X0], dv_side.neg[clx_pkg::LANE_X0], cx_r);
      res_nxt.hit0_y = place(dv_quo[clx_pkg::LANE_Y0], dv_side.neg[clx_pkg::LANE_Y0], cy_r);
      if (dv_side.tangent) begin
        res_nxt.hit_count = clx_pkg::HITS_ONE;
      end else begin
        res_nxt.hit_count = clx_pkg::HITS_TWO;
        res_nxt.hit1_x = place(dv_quo[clx_pkg::LANE_X1], dv_side.neg[clx_pkg::LANE_X1], cx_r);
        res_nxt.hit1_y = place(dv_quo[clx_pkg::LANE_Y1], dv_side.neg[clx_pkg::LANE_Y1], cy_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_valid;
    end
    out_data_r <= res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A root leaves the square-root pipeline only for an item that entered it.
  a_sqrt_origin: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid |-> $past(v5_r, SQW))
    else $error("square root produced a result without an entering item");

  // Every result traces back to an item that the block took.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(accept, LATENCY))
    else $error("result strobe without an item taken at the expected time");

  // Unless two points were found, the second point reads as zero.
  a_hit1_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_data_r.degenerate || out_data_r.hit_count != clx_pkg::HITS_TWO))
    |-> (out_data_r.hit1_x == '0 && out_data_r.hit1_y == '0))
    else $error("second intersection not cleared");

endmodule

// ===== test/circle_line_intersection_tb.sv =====
module circle_line_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry predictor and queue of expected intersections.
  class hit_board;
    logic signed [clx_pkg::CW-1:0] cx, cy;
    logic [clx_pkg::RW-1:0] rad;
    clx_pkg::out_t pending[$];
    int mismatches;

    function new();
      cx = '0;
      cy = '0;
      rad = '0;
      mismatches = 0;
    endfunction

    function logic [clx_pkg::CW-1:0] clamp(logic signed [127:0] v);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (clx_pkg::CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[clx_pkg::CW-1:0];
    endfunction

    // Floor square root of a nonnegative value of up to 84 bits.
    function logic [63:0] root(logic [127:0] v);
      logic [63:0] r, c;
      r = '0;
      for (int b = 41; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
    endfunction

    // Work out the intersections of one line item with the held circle.
    function void note_line(clx_pkg::in_t it);
      logic signed [127:0] x1, y1, x2, y2, dx, dy, dr2, det, disc, s, sg, ady;
      logic signed [127:0] bx, by, ex, ey;
      clx_pkg::out_t r;
      x1 = 128'(it.first_x) - 128'(cx);
      y1 = 128'(it.first_y) - 128'(cy);
      x2 = 128'(it.second_x) - 128'(cx);
      y2 = 128'(it.second_y) - 128'(cy);
      dx = x2 - x1;
      dy = y2 - y1;
      dr2 = dx * dx + dy * dy;
      det = x1 * y2 - x2 * y1;
      r = '0;
      if (dr2 == 0) begin
        r.degenerate = 1'b1;
      end else begin
        disc = 128'(rad) * 128'(rad) * dr2 - det * det;
        if (disc >= 0) begin
          s = $signed(128'(root(disc)));
          sg = (dy < 0) ? -128'sd1 : 128'sd1;
          ady = (dy < 0) ? -dy : dy;
          bx = det * dy;
          by = -det * dx;
          ex = sg * dx * s;
          ey = ady * s;
          // SystemVerilog signed division truncates toward zero.
          r.hit0_x = clamp((bx + ex) / dr2 + 128'(cx));
          r.hit0_y = clamp((by + ey) / dr2 + 128'(cy));
          if (disc == 0) begin
            r.hit_count = clx_pkg::HITS_ONE;
          end else begin
            r.hit_count = clx_pkg::HITS_TWO;
            r.hit1_x = clamp((bx - ex) / dr2 + 128'(cx));
            r.hit1_y = clamp((by - ey) / dr2 + 128'(cy));
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_hit(clx_pkg::out_t got);
      clx_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want cnt=%0d h0=(%0d,%0d) h1=(%0d,%0d) dg=%0d",
                   want.hit_count, want.hit0_x, want.hit0_y, want.hit1_x, want.hit1_y,
                   want.degenerate);
          $display("          got  cnt=%0d h0=(%0d,%0d) h1=(%0d,%0d) dg=%0d",
                   got.hit_count, got.hit0_x, got.hit0_y, got.hit1_x, got.hit1_y,
                   got.degenerate);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  clx_pkg::in_t in_data = '0;
  logic out_strobe;
  clx_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [clx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [clx_pkg::CW-1:0] cfg_data = '0;

  hit_board board = new();

  always #4 clk = ~clk;

  circle_line_intersection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Results cannot be held off, so every strobed cycle is checked at its closing edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_hit(out_data);
  end

  // Write one circle register; the predictor follows at the accepting edge.
  // The caller drops cfg_valid once its last write is done.
  task automatic write_reg(logic [clx_pkg::CFG_IDX_W-1:0] idx, logic [clx_pkg::CW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      clx_pkg::REG_CENTER_X: board.cx = val;
      clx_pkg::REG_CENTER_Y: board.cy = val;
      clx_pkg::REG_RADIUS:   board.rad = val[clx_pkg::RW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_circle(logic [clx_pkg::CW-1:0] x, logic [clx_pkg::CW-1:0] y,
                            logic [clx_pkg::CW-1:0] r);
    write_reg(clx_pkg::REG_CENTER_X, x);
    write_reg(clx_pkg::REG_CENTER_Y, y);
    write_reg(clx_pkg::REG_RADIUS, r);
    cfg_valid <= 1'b0;
  endtask

  // Offer one item and hold it until busy is low at an edge. The caller decides
  // whether start drops afterwards, so back-to-back items keep start high.
  task automatic send_line(clx_pkg::in_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    board.note_line(it);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Let the pipeline drain before the circle changes.
  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [clx_pkg::CW-1:0] rnd_coord(int span);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return clx_pkg::CW'($urandom);
    if (mode == 1)
      return $urandom_range(0, 1) ? {1'b0, {(clx_pkg::CW-1){1'b1}}}
                                  : {1'b1, {(clx_pkg::CW-1){1'b0}}};
    return clx_pkg::CW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random lines placed around the circle: mostly through or near it, some tangent
  // attempts along the radius distance, some degenerate, some arbitrary.
  task automatic random_phase(int count, int span);
    clx_pkg::in_t it;
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      it.first_x = board.cx + rnd_coord(span);
      it.first_y = board.cy + rnd_coord(span);
      case ($urandom_range(0, 9))
        0: begin
          it.second_x = it.first_x;
          it.second_y = it.first_y;
        end
        1: begin
          // Horizontal line at distance radius: tangent.
          it.first_y = board.cy + clx_pkg::CW'(board.rad);
          it.second_x = it.first_x + clx_pkg::CW'($urandom_range(1, 500));
          it.second_y = it.first_y;
        end
        2: begin
          it.second_x = clx_pkg::CW'($urandom);
          it.second_y = clx_pkg::CW'($urandom);
        end
        default: begin
          it.second_x = board.cx + rnd_coord(span);
          it.second_y = board.cy + rnd_coord(span);
        end
      endcase
      send_line(it);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        pause_sender();
      end else begin
        burst--;
      end
    end
    drain();
  endtask

  initial begin
    clx_pkg::in_t it;
    logic [clx_pkg::CW-1:0] mx, mn;
    mx = {1'b0, {(clx_pkg::CW-1){1'b1}}};
    mn = {1'b1, {(clx_pkg::CW-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero radius, then a circle of radius 256 at the origin with secant, tangent, miss,
    // degenerate, vertical, extreme and saturating lines.
    send_line('{20'sd0, 20'sd0, 20'sd256, 20'sd0});
    send_line('{20'sd5, 20'sd5, 20'sd5, 20'sd5});
    drain();
    set_circle(20'd0, 20'd0, 20'd256);
    send_line('{-20'sd512, 20'sd0, 20'sd512, 20'sd0});
    send_line('{-20'sd512, 20'sd256, 20'sd512, 20'sd256});
    send_line('{-20'sd512, 20'sd600, 20'sd512, 20'sd600});
    send_line('{20'sd100, 20'sd100, 20'sd100, 20'sd100});
    send_line('{20'sd0, -20'sd512, 20'sd0, 20'sd512});
    send_line('{20'sd0, 20'sd512, 20'sd0, -20'sd512});
    send_line('{mn, mn, mx, mx});
    send_line('{mx, mn, mn, mx});
    send_line('{mn, mn, mn, mn});
    drain();
    set_circle(mx, mn, {1'b0, mx[clx_pkg::CW-2:0]});
    send_line('{mn, mn, mx, mx});
    send_line('{mx, mx, mn, mx});
    send_line('{mx, mn, mx, mx});
    send_line('{mn, mx, mx, mn});
    send_line('{20'sd0, 20'sd0, 20'sd1, 20'sd0});
    drain();
    // An index past the radius register must leave the circle alone.
    write_reg(2'd3, mx);
    set_circle(mn, mx, 20'd1);
    send_line('{mn, mx, mx, mx});
    send_line('{mn, mn, mn, mx});
    drain();

    // Random phases over several circles, small spans most of the time.
    set_circle(20'd0, 20'd0, 20'd3000);
    random_phase(500, 6000);
    set_circle(clx_pkg::CW'(-20'sd40000), clx_pkg::CW'(20'sd70000), 20'd200000);
    random_phase(450, 300000);
    set_circle(clx_pkg::CW'($urandom), clx_pkg::CW'($urandom),
               clx_pkg::CW'($urandom_range(0, 524287)));
    random_phase(450, 524287);
    set_circle(20'd512, clx_pkg::CW'(-20'sd1024), 20'd0);
    random_phase(150, 2000);
    set_circle(clx_pkg::CW'($urandom), clx_pkg::CW'($urandom), 20'd40);
    random_phase(300, 200);

    // Results still owed at the end count as failures too.
    if (board.mismatches == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== circle_line_intersection.f =====
hw/rtl/clx_pkg.sv
hw/rtl/clx_sqrt.sv
hw/rtl/clx_div.sv
hw/rtl/circle_line_intersection.sv
test/circle_line_intersection_tb.sv
